// ----- design/rhpg_pkg.sv -----
// Package for the rotated hand point generator: shared types, constants,
// the Q1.14 quarter-wave sine table and the Q.14 rounding helper.
// No dependencies.
package rhpg_pkg;

    // Default parameter values
    localparam int MAX_STEPS_DEF  = 128;
    localparam int HALF_WIDTH_DEF = 2;

    // Register reset values
    localparam logic [7:0] CENTRE_X_RST = 8'd64;
    localparam logic [7:0] CENTRE_Y_RST = 8'd80;

    // Register indexes (byte address bit 2)
    localparam logic REG_CENTRE_X = 1'b0;
    localparam logic REG_CENTRE_Y = 1'b1;

    // Quadrant codes for the fill pixel; axis angles get none
    localparam logic [2:0] QD_NONE = 3'd0;
    localparam logic [2:0] QD_1    = 3'd1;
    localparam logic [2:0] QD_2    = 3'd2;
    localparam logic [2:0] QD_3    = 3'd3;
    localparam logic [2:0] QD_4    = 3'd4;

    // Point indexes: P itself, A=(i,j-1), B=(i-1,j), C=(i-1,j-1)
    localparam int PT_P = 0;
    localparam int PT_A = 1;
    localparam int PT_B = 2;
    localparam int PT_C = 3;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam int          FIX_W  = 24;   // Q.14 coordinate width
    localparam int          PIX_W  = 10;   // pixel coordinate width

    // Control travelling alongside each request
    typedef struct packed {
        logic       valid;
        logic       nbr;    // neighbours exist (i > -half width, j > 0)
        logic [2:0] quad;
    } t_ctl;

    typedef logic [14:0] t_sin_tab [0:90];

    // Sine table, built at elaboration from a Q.30 Taylor series
    function automatic t_sin_tab build_sin_tab();
        t_sin_tab    tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] sum;
        for (int d = 0; d <= 90; d++) begin
            x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
            x2   = (x * x) >> 30;
            term = x;
            pos  = x;
            neg  = 64'd0;
            for (int n = 1; n <= 8; n++) begin
                term = (term * x2) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
            sum    = (pos > neg) ? pos - neg : 64'd0;
            tab[d] = 15'((sum + 64'd32768) >> 16);
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_tab();

    // Q.14 to pixel: negatives truncate toward zero, positives round with
    // an exact half going down
    function automatic logic [PIX_W-1:0] round_q14(input logic signed [FIX_W-1:0] v);
        logic [FIX_W-1:0] mag;
        logic [PIX_W-1:0] q;
        mag = FIX_W'(-v);
        q   = v[FIX_W-1-:PIX_W];
        if (v < 0) begin
            q = PIX_W'(0) - mag[FIX_W-1-:PIX_W];
        end else if (v[13:0] > 14'd8192) begin
            q = q + PIX_W'(1);
        end
        return q;
    endfunction

endpackage

// ----- design/rhpg_trig.sv -----
// Front end: angle reduction and input clamping, then sine/cosine lookup.
// Two register stages. Depends on rhpg_pkg.
module rhpg_trig import rhpg_pkg::*; #(
    parameter int MAX_STEPS  = MAX_STEPS_DEF,
    parameter int HALF_WIDTH = HALF_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [8:0]         i_angle_deg,
    input  logic signed [2:0]  i_lateral,
    input  logic [6:0]         i_step,
    output t_ctl               o_ctl,
    output logic signed [4:0]  o_lat,
    output logic [6:0]         o_step,
    output logic signed [15:0] o_sin,
    output logic signed [15:0] o_cos
);

    localparam logic signed [4:0] HW    = 5'(HALF_WIDTH);
    localparam logic [8:0]        J_MAX = 9'(MAX_STEPS - 1);

    // Stage A registers
    t_ctl              r_ctl_a;
    logic [8:0]        r_ang;
    logic signed [4:0] r_lat_a;
    logic [6:0]        r_step_a;

    logic [8:0]        n_ang;
    logic signed [4:0] n_lat;
    logic [6:0]        n_step;
    t_ctl              n_ctl_a;

    // Reduce angle, clamp lateral and step
    always_comb begin
        n_ang  = (i_angle_deg >= 9'd360) ? i_angle_deg - 9'd360 : i_angle_deg;
        n_lat  = 5'(i_lateral);
        if (n_lat < -HW) begin
            n_lat = -HW;
        end
        if (n_lat > HW) begin
            n_lat = HW;
        end
        n_step = (9'(i_step) > J_MAX) ? J_MAX[6:0] : i_step;
        n_ctl_a.valid = i_valid;
        n_ctl_a.nbr   = (n_lat > -HW) && (n_step != 7'd0);
        n_ctl_a.quad  = QD_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
        end else begin
            r_ctl_a <= n_ctl_a;
        end
        r_ang    <= n_ang;
        r_lat_a  <= n_lat;
        r_step_a <= n_step;
    end

    // Quadrant folding onto the 0..90 table
    logic [6:0] n_sd;
    logic [6:0] n_cd;
    logic       n_sneg;
    logic       n_cneg;
    logic [2:0] n_quad;

    always_comb begin
        if (r_ang <= 9'd90) begin
            n_sd = 7'(r_ang);            n_cd = 7'(9'd90 - r_ang);
            n_sneg = 1'b0;               n_cneg = 1'b0;
        end else if (r_ang <= 9'd180) begin
            n_sd = 7'(9'd180 - r_ang);   n_cd = 7'(r_ang - 9'd90);
            n_sneg = 1'b0;               n_cneg = 1'b1;
        end else if (r_ang <= 9'd270) begin
            n_sd = 7'(r_ang - 9'd180);   n_cd = 7'(9'd270 - r_ang);
            n_sneg = 1'b1;               n_cneg = 1'b1;
        end else begin
            n_sd = 7'(9'd360 - r_ang);   n_cd = 7'(r_ang - 9'd270);
            n_sneg = 1'b1;               n_cneg = 1'b0;
        end
        if (r_ang == 9'd0 || r_ang == 9'd90 || r_ang == 9'd180 || r_ang == 9'd270) begin
            n_quad = QD_NONE;
        end else if (r_ang < 9'd90) begin
            n_quad = QD_1;
        end else if (r_ang < 9'd180) begin
            n_quad = QD_2;
        end else if (r_ang < 9'd270) begin
            n_quad = QD_3;
        end else begin
            n_quad = QD_4;
        end
    end

    logic signed [15:0] n_sin;
    logic signed [15:0] n_cos;
    assign n_sin = n_sneg ? -$signed({1'b0, SIN_TAB[n_sd]}) : $signed({1'b0, SIN_TAB[n_sd]});
    assign n_cos = n_cneg ? -$signed({1'b0, SIN_TAB[n_cd]}) : $signed({1'b0, SIN_TAB[n_cd]});

    // Stage B registers
    t_ctl               r_ctl_b;
    logic signed [4:0]  r_lat_b;
    logic [6:0]         r_step_b;
    logic signed [15:0] r_sin;
    logic signed [15:0] r_cos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_b <= '0;
        end else begin
            r_ctl_b <= '{valid: r_ctl_a.valid, nbr: r_ctl_a.nbr, quad: n_quad};
        end
        r_lat_b  <= r_lat_a;
        r_step_b <= r_step_a;
        r_sin    <= n_sin;
        r_cos    <= n_cos;
    end

    assign o_ctl  = r_ctl_b;
    assign o_lat  = r_lat_b;
    assign o_step = r_step_b;
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;

endmodule

// ----- design/rhpg_proj.sv -----
// Projection: products, pivot-relative sums and the four Q.14 points
// (P and its three neighbours). Three register stages. Depends on rhpg_pkg.
module rhpg_proj import rhpg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    input  logic signed [4:0]       i_lat,
    input  logic [6:0]              i_step,
    input  logic signed [15:0]      i_sin,
    input  logic signed [15:0]      i_cos,
    input  logic [7:0]              i_centre_x,
    input  logic [7:0]              i_centre_y,
    output t_ctl                    o_ctl,
    output logic signed [FIX_W-1:0] o_fx [4],
    output logic signed [FIX_W-1:0] o_fy [4]
);

    // Stage C: four products
    t_ctl               r_ctl_c;
    logic signed [20:0] r_ic;
    logic signed [20:0] r_is;
    logic signed [23:0] r_js;
    logic signed [23:0] r_jc;
    logic signed [15:0] r_s_c;
    logic signed [15:0] r_c_c;

    logic signed [20:0] n_ic;
    logic signed [20:0] n_is;
    logic signed [23:0] n_js;
    logic signed [23:0] n_jc;
    logic signed [7:0]  step_s;

    assign step_s = $signed({1'b0, i_step});
    assign n_ic   = i_lat * i_cos;
    assign n_is   = i_lat * i_sin;
    assign n_js   = step_s * i_sin;
    assign n_jc   = step_s * i_cos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_c <= '0;
        end else begin
            r_ctl_c <= i_ctl;
        end
        r_ic  <= n_ic;
        r_is  <= n_is;
        r_js  <= n_js;
        r_jc  <= n_jc;
        r_s_c <= i_sin;
        r_c_c <= i_cos;
    end

    // Stage D: point P in Q.14
    t_ctl                    r_ctl_d;
    logic signed [FIX_W-1:0] r_bx;
    logic signed [FIX_W-1:0] r_by;
    logic signed [15:0]      r_s_d;
    logic signed [15:0]      r_c_d;

    logic signed [FIX_W-1:0] cxq;
    logic signed [FIX_W-1:0] cyq;
    logic signed [FIX_W-1:0] n_bx;
    logic signed [FIX_W-1:0] n_by;

    assign cxq  = $signed({2'b00, i_centre_x, 14'd0});
    assign cyq  = $signed({2'b00, i_centre_y, 14'd0});
    assign n_bx = cxq + r_ic + r_js;
    assign n_by = cyq + r_is - r_jc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_d <= '0;
        end else begin
            r_ctl_d <= r_ctl_c;
        end
        r_bx  <= n_bx;
        r_by  <= n_by;
        r_s_d <= r_s_c;
        r_c_d <= r_c_c;
    end

    // Stage E: neighbours by stepping back along j and across i
    t_ctl                    r_ctl_e;
    logic signed [FIX_W-1:0] r_fx [4];
    logic signed [FIX_W-1:0] r_fy [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_e <= '0;
        end else begin
            r_ctl_e <= r_ctl_d;
        end
        r_fx[PT_P] <= r_bx;
        r_fy[PT_P] <= r_by;
        r_fx[PT_A] <= r_bx - r_s_d;
        r_fy[PT_A] <= r_by + r_c_d;
        r_fx[PT_B] <= r_bx - r_c_d;
        r_fy[PT_B] <= r_by - r_s_d;
        r_fx[PT_C] <= r_bx - r_c_d - r_s_d;
        r_fy[PT_C] <= r_by - r_s_d + r_c_d;
    end

    assign o_ctl = r_ctl_e;
    assign o_fx  = r_fx;
    assign o_fy  = r_fy;

endmodule

// ----- design/rhpg_gap.sv -----
// Back end: rounds the four points to pixels, runs the diagonal gap test
// and registers the result. Two register stages. Depends on rhpg_pkg.
module rhpg_gap import rhpg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    input  logic signed [FIX_W-1:0] i_fx [4],
    input  logic signed [FIX_W-1:0] i_fy [4],
    output logic                    o_valid,
    output logic [PIX_W-1:0]        o_pixel_x,
    output logic [PIX_W-1:0]        o_pixel_y,
    output logic                    o_fill_valid,
    output logic [PIX_W-1:0]        o_fill_x,
    output logic [PIX_W-1:0]        o_fill_y
);

    // Stage F: rounding
    t_ctl             r_ctl_f;
    logic [PIX_W-1:0] r_rx [4];
    logic [PIX_W-1:0] r_ry [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_f <= '0;
        end else begin
            r_ctl_f <= i_ctl;
        end
        for (int k = 0; k < 4; k++) begin
            r_rx[k] <= round_q14(i_fx[k]);
            r_ry[k] <= round_q14(i_fy[k]);
        end
    end

    // Gap test and quadrant-dependent fill pixel
    logic             gap;
    logic             n_fv;
    logic [PIX_W-1:0] n_fx;
    logic [PIX_W-1:0] n_fy;

    assign gap = r_ctl_f.valid && r_ctl_f.nbr
              && (r_rx[PT_P] != r_rx[PT_A]) && (r_ry[PT_P] != r_ry[PT_A])
              && (r_rx[PT_B] != r_rx[PT_C]) && (r_ry[PT_B] != r_ry[PT_C])
              && (r_ry[PT_A] != r_ry[PT_C]);

    always_comb begin
        n_fv = gap;
        n_fx = '0;
        n_fy = '0;
        case (r_ctl_f.quad)
            QD_1: begin
                n_fx = r_rx[PT_C] + PIX_W'(1);
                n_fy = r_ry[PT_C];
            end
            QD_2: begin
                n_fx = r_rx[PT_A] + PIX_W'(1);
                n_fy = r_ry[PT_A];
            end
            QD_3: begin
                n_fx = r_rx[PT_A];
                n_fy = r_ry[PT_A] + PIX_W'(1);
            end
            QD_4: begin
                n_fx = r_rx[PT_C];
                n_fy = r_ry[PT_C] - PIX_W'(1);
            end
            default: begin
                n_fv = 1'b0;
            end
        endcase
        if (!n_fv) begin
            n_fx = '0;
            n_fy = '0;
        end
    end

    // Stage G: output register
    logic             r_valid;
    logic [PIX_W-1:0] r_px;
    logic [PIX_W-1:0] r_py;
    logic             r_fv;
    logic [PIX_W-1:0] r_fx_o;
    logic [PIX_W-1:0] r_fy_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_ctl_f.valid;
        end
        r_px   <= r_rx[PT_P];
        r_py   <= r_ry[PT_P];
        r_fv   <= n_fv;
        r_fx_o <= n_fx;
        r_fy_o <= n_fy;
    end

    assign o_valid      = r_valid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_fill_valid = r_fv;
    assign o_fill_x     = r_fx_o;
    assign o_fill_y     = r_fy_o;

endmodule

// ----- design/rotated_hand_point_generator.sv -----
// Top level of the rotated hand point generator: register port, pivot
// registers and the seven-stage pipeline. Depends on rhpg_pkg, rhpg_trig,
// rhpg_proj and rhpg_gap.
//
// Usage:
//   A request (angle, lateral offset, step) is taken at each rising edge with
//   start high and busy low. busy is never raised, so one request per clock
//   is sustained; every stage is a register that advances every cycle.
//   Each request gives exactly one result on o_pixel_x/o_pixel_y with the
//   gap-fill fields, marked by o_valid for one cycle. Each request passes
//   through stage registers A to G in order; its result is shown from G.
//   Results come out in request order; the receiver takes each one in the
//   cycle it is shown and cannot hold it off.
//   The pivot registers sit at byte addresses 0 (centre x) and 4
//   (centre y) of the APB-style port; write them only while no request is
//   in flight. Reset clears the pipeline valid bits and sets the pivot to
//   (64, 80); requests are taken from the first cycle after reset.
module rotated_hand_point_generator import rhpg_pkg::*; #(
    parameter int MAX_STEPS  = MAX_STEPS_DEF,
    parameter int HALF_WIDTH = HALF_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Request channel
    input  logic              start,
    output logic              busy,
    input  logic [8:0]        i_angle_deg,
    input  logic signed [2:0] i_lateral,
    input  logic [6:0]        i_step,
    // Result channel
    output logic              o_valid,
    output logic [9:0]        o_pixel_x,
    output logic [9:0]        o_pixel_y,
    output logic              o_fill_valid,
    output logic [9:0]        o_fill_x,
    output logic [9:0]        o_fill_y
);

    // Pivot registers
    logic [7:0] r_centre_x;
    logic [7:0] r_centre_y;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_x <= CENTRE_X_RST;
            r_centre_y <= CENTRE_Y_RST;
        end else if (wr_en) begin
            if (paddr[2] == REG_CENTRE_X) begin
                r_centre_x <= pwdata[7:0];
            end else begin
                r_centre_y <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_CENTRE_Y) ? {24'd0, r_centre_y} : {24'd0, r_centre_x};

    // Pipeline
    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    t_ctl                    trig_ctl;
    logic signed [4:0]       trig_lat;
    logic [6:0]              trig_step;
    logic signed [15:0]      trig_sin;
    logic signed [15:0]      trig_cos;
    t_ctl                    proj_ctl;
    logic signed [FIX_W-1:0] proj_fx [4];
    logic signed [FIX_W-1:0] proj_fy [4];

    rhpg_trig #(
        .MAX_STEPS  (MAX_STEPS),
        .HALF_WIDTH (HALF_WIDTH)
    ) u_trig (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_angle_deg (i_angle_deg),
        .i_lateral   (i_lateral),
        .i_step      (i_step),
        .o_ctl       (trig_ctl),
        .o_lat       (trig_lat),
        .o_step      (trig_step),
        .o_sin       (trig_sin),
        .o_cos       (trig_cos)
    );

    rhpg_proj u_proj (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (trig_ctl),
        .i_lat      (trig_lat),
        .i_step     (trig_step),
        .i_sin      (trig_sin),
        .i_cos      (trig_cos),
        .i_centre_x (r_centre_x),
        .i_centre_y (r_centre_y),
        .o_ctl      (proj_ctl),
        .o_fx       (proj_fx),
        .o_fy       (proj_fy)
    );

    rhpg_gap u_gap (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (proj_ctl),
        .i_fx         (proj_fx),
        .i_fy         (proj_fy),
        .o_valid      (o_valid),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_fill_valid (o_fill_valid),
        .o_fill_x     (o_fill_x),
        .o_fill_y     (o_fill_y)
    );

    // Every result stems from an accepted request
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 7))
        else $error("result without a matching request");

    // No fill pixel on a cycle without a result
    a_fill_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_fill_valid)
        else $error("fill flagged without a result");

    // Fill coordinates are zero when there is no fill pixel
    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_fill_valid) |-> (o_fill_x == 10'd0 && o_fill_y == 10'd0))
        else $error("fill coordinates not cleared");

    // A write to the centre x register lands in r_centre_x
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && paddr[2] == REG_CENTRE_X) |=> (r_centre_x == $past(pwdata[7:0])))
        else $error("centre x write lost");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Testbench for rotated_hand_point_generator: a predictor class tracks the
// pivot registers and queues the pixels each accepted request should give.
// Depends on rhpg_pkg and the design under design/.
module tb;
    import rhpg_pkg::*;

    localparam int SETTLE_CYCLES = 12;   // pipeline is seven deep

    // Predicts the point and gap-fill pixel for each request, in order
    class hand_point_predictor;
        typedef struct packed {
            logic [9:0] px;
            logic [9:0] py;
            logic       fv;
            logic [9:0] fx;
            logic [9:0] fy;
        } t_hand_pixel;

        int          sine_q14 [0:90];
        int          centre_x;
        int          centre_y;
        int          errors;
        t_hand_pixel awaited [$];

        // Quarter-wave sine in Q1.14, from a Q.30 Taylor series
        function new();
            longint unsigned pi_q30;
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint unsigned pos;
            longint unsigned neg;
            longint unsigned sum;
            longint unsigned dd;
            longint unsigned n;
            pi_q30   = 64'd3373259426;
            centre_x = int'(CENTRE_X_RST);
            centre_y = int'(CENTRE_Y_RST);
            errors   = 0;
            for (int d = 0; d <= 90; d++) begin
                dd   = 64'(d);
                x    = (dd * pi_q30 + 64'd90) / 64'd180;
                x2   = (x * x) >> 30;
                term = x;
                pos  = x;
                neg  = 64'd0;
                for (n = 1; n <= 8; n++) begin
                    term = (term * x2) >> 30;
                    term = term / ((2 * n) * (2 * n + 1));
                    if (n[0]) begin
                        neg = neg + term;
                    end else begin
                        pos = pos + term;
                    end
                end
                sum         = (pos > neg) ? pos - neg : 64'd0;
                sine_q14[d] = int'((sum + 64'd32768) >> 16);
            end
        endfunction

        function void set_centre(logic idx, logic [7:0] val);
            if (idx == REG_CENTRE_X) begin
                centre_x = int'(val);
            end else begin
                centre_y = int'(val);
            end
        endfunction

        function int pending_count();
            return awaited.size();
        endfunction

        // Q.14 to pixel: negatives truncate, positives round with half down
        function int to_pixel(int v);
            if (v < 0) begin
                return -((-v) >>> 14);
            end
            return (v >>> 14) + (((v & 16383) > 8192) ? 1 : 0);
        endfunction

        function void locate(int s, int c, int i, int j, output int px, output int py);
            px = to_pixel(centre_x * 16384 + i * c + j * s);
            py = to_pixel(centre_y * 16384 + i * s - j * c);
        endfunction

        function void note_request(logic [8:0] ang, logic signed [2:0] lat, logic [6:0] stp);
            int          a;
            int          i;
            int          j;
            int          s;
            int          c;
            int          px;
            int          py;
            int          ax;
            int          ay;
            int          bx;
            int          by;
            int          cx;
            int          cy;
            int          fx = 0;
            int          fy = 0;
            logic        fv = 1'b0;
            logic [2:0]  quad;
            t_hand_pixel e;
            a = int'(ang) % 360;
            i = int'(lat);
            j = int'(stp);
            if (i < -HALF_WIDTH_DEF) i = -HALF_WIDTH_DEF;
            if (i > HALF_WIDTH_DEF)  i = HALF_WIDTH_DEF;
            if (j > MAX_STEPS_DEF - 1) j = MAX_STEPS_DEF - 1;

            // sine and cosine by quadrant symmetry
            if (a <= 90) begin
                s = sine_q14[a];
                c = sine_q14[90 - a];
            end else if (a <= 180) begin
                s = sine_q14[180 - a];
                c = -sine_q14[a - 90];
            end else if (a <= 270) begin
                s = -sine_q14[a - 180];
                c = -sine_q14[270 - a];
            end else begin
                s = -sine_q14[360 - a];
                c = sine_q14[a - 270];
            end

            if (a > 0 && a < 90)         quad = QD_1;
            else if (a > 90 && a < 180)  quad = QD_2;
            else if (a > 180 && a < 270) quad = QD_3;
            else if (a > 270)            quad = QD_4;
            else                         quad = QD_NONE;

            locate(s, c, i, j, px, py);

            // diagonal gap test against the three neighbours
            if (i > -HALF_WIDTH_DEF && j > 0) begin
                locate(s, c, i, j - 1, ax, ay);
                locate(s, c, i - 1, j, bx, by);
                locate(s, c, i - 1, j - 1, cx, cy);
                if (px != ax && py != ay && bx != cx && by != cy && ay != cy) begin
                    case (quad)
                        QD_1: begin
                            fv = 1'b1; fx = cx + 1; fy = cy;
                        end
                        QD_2: begin
                            fv = 1'b1; fx = ax + 1; fy = ay;
                        end
                        QD_3: begin
                            fv = 1'b1; fx = ax; fy = ay + 1;
                        end
                        QD_4: begin
                            fv = 1'b1; fx = cx; fy = cy - 1;
                        end
                        default: begin
                            fv = 1'b0;
                        end
                    endcase
                end
            end

            e.px = 10'(px);
            e.py = 10'(py);
            e.fv = fv;
            e.fx = 10'(fx);
            e.fy = 10'(fy);
            awaited.push_back(e);
        endfunction

        function void check_result(logic [9:0] px, logic [9:0] py, logic fv,
                                   logic [9:0] fx, logic [9:0] fy);
            t_hand_pixel e;
            if (awaited.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (px !== e.px) begin
                $error("pixel_x: expected %0d, got %0d", $signed(e.px), $signed(px));
                errors++;
            end
            if (py !== e.py) begin
                $error("pixel_y: expected %0d, got %0d", $signed(e.py), $signed(py));
                errors++;
            end
            if (fv !== e.fv) begin
                $error("fill_valid: expected %0d, got %0d", e.fv, fv);
                errors++;
            end
            if (fx !== e.fx) begin
                $error("fill_x: expected %0d, got %0d", $signed(e.fx), $signed(fx));
                errors++;
            end
            if (fy !== e.fy) begin
                $error("fill_y: expected %0d, got %0d", $signed(e.fy), $signed(fy));
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              start = 1'b0;
    logic              busy;
    logic [8:0]        i_angle_deg = '0;
    logic signed [2:0] i_lateral = '0;
    logic [6:0]        i_step = '0;
    logic              o_valid;
    logic [9:0]        o_pixel_x;
    logic [9:0]        o_pixel_y;
    logic              o_fill_valid;
    logic [9:0]        o_fill_x;
    logic [9:0]        o_fill_y;

    hand_point_predictor points = new();
    int sender_idle_pct = 0;

    // Directed requests: axes, diagonals, wrap-around angles, clamped fields
    int dir_ang  [20] = '{0, 90, 180, 270, 45, 135, 225, 315, 1, 359,
                          360, 511, 89, 91, 181, 271, 30, 150, 210, 330};
    int dir_lat  [20] = '{1, 2, -1, 0, 2, 1, 0, -1, 2, -4,
                          3, -3, 1, 2, 0, 1, -2, 2, 1, 0};
    int dir_step [20] = '{5, 127, 1, 0, 127, 64, 40, 100, 1, 10,
                          20, 127, 0, 33, 77, 50, 127, 1, 96, 63};

    rotated_hand_point_generator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .i_angle_deg  (i_angle_deg),
        .i_lateral    (i_lateral),
        .i_step       (i_step),
        .o_valid      (o_valid),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_fill_valid (o_fill_valid),
        .o_fill_x     (o_fill_x),
        .o_fill_y     (o_fill_y)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Monitor: check results shown this cycle, then note accepted requests
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                points.check_result(o_pixel_x, o_pixel_y, o_fill_valid, o_fill_x, o_fill_y);
            end
            if (start && !busy) begin
                points.note_request(i_angle_deg, i_lateral, i_step);
            end
        end
    end

    // Present one request and hold it until taken; idle afterwards at random
    task automatic send_request(input logic [8:0] ang, input logic signed [2:0] lat,
                                input logic [6:0] stp);
        start       <= 1'b1;
        i_angle_deg <= ang;
        i_lateral   <= lat;
        i_step      <= stp;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait for every outstanding request to come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (points.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        points.set_centre(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic move_pivot(input logic [7:0] x, input logic [7:0] y);
        drain_results();
        apb_write(REG_CENTRE_X, x);
        apb_write(REG_CENTRE_Y, y);
    endtask

    // Random requests, weighted towards axis angles and field extremes
    task automatic run_random(input int count);
        logic [8:0]        ang;
        logic signed [2:0] lat;
        logic [6:0]        stp;
        int                pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                ang = 9'($urandom_range(360, 511));
            end else if (pick < 20) begin
                ang = 9'((90 * $urandom_range(0, 3) + 359 + $urandom_range(0, 2)) % 360);
            end else begin
                ang = 9'($urandom_range(0, 359));
            end
            if ($urandom_range(99) < 85) begin
                lat = 3'($urandom_range(0, 4) - 2);
            end else begin
                lat = 3'($urandom_range(0, 7));
            end
            pick = $urandom_range(99);
            if (pick < 4)       stp = 7'd0;
            else if (pick < 7)  stp = 7'd1;
            else if (pick < 10) stp = 7'd127;
            else                stp = 7'($urandom_range(0, 127));
            send_request(ang, lat, stp);
            // now and then let the pipeline run dry
            if ($urandom_range(199) == 0) begin
                drain_results();
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset pivot
        sender_idle_pct = 15;
        for (int k = 0; k < 20; k++) begin
            send_request(9'(dir_ang[k]), 3'(dir_lat[k]), 7'(dir_step[k]));
        end

        move_pivot(8'd0, 8'd0);
        run_random(650);

        sender_idle_pct = 57;
        move_pivot(8'd255, 8'd255);
        run_random(650);

        sender_idle_pct = 0;
        move_pivot(8'd0, 8'd255);
        run_random(300);
        move_pivot(8'd255, 8'd0);
        run_random(200);
        move_pivot(8'($urandom), 8'($urandom));
        run_random(150);

        drain_results();
        if (points.errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #200000;
        $display("tb failed");
        $finish;
    end

endmodule
